FILE: hdl/tamf_pkg.sv
// Shared constants and types for the three-axis median filter.
`default_nettype none

package tamf_pkg;

  // Field widths.
  localparam int SAMPLE_W = 16;
  localparam int DATA_W   = 17;
  localparam int AXES     = 3;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_FIELD_W = AXES * DATA_W;
  localparam int OUT_TDATA_W = 56;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  // Configuration port.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z = 2'd2;

  // Per-cycle controls that the top level hands to every lane.
  typedef struct packed {
    logic wr_en;    // write the corrected sample into the window
    logic rank_en;  // capture the window and its middle-rank flags
  } tamf_lane_ctl_t;

endpackage

`default_nettype wire

FILE: hdl/tamf_lane.sv
// One axis lane: offset correction, ring window, rank stage and median select.
`default_nettype none

module tamf_lane #(
  parameter int DEPTH = 5,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire                                       clk,
  input  wire                                       rst,
  input  tamf_pkg::tamf_lane_ctl_t                  ctl,
  input  wire        [PTR_W-1:0]                    wr_pos,
  input  wire signed [tamf_pkg::SAMPLE_W-1:0]       sample,
  input  wire signed [tamf_pkg::SAMPLE_W-1:0]       offset,
  output logic signed [tamf_pkg::DATA_W-1:0]        median
);
  import tamf_pkg::*;

  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int MID_HI = DEPTH / 2;
  localparam int MID_LO = (DEPTH % 2 == 0) ? (DEPTH / 2 - 1) : (DEPTH / 2);

  logic signed [DATA_W-1:0] window [DEPTH];
  logic signed [DATA_W-1:0] snap   [DEPTH];
  logic        [CNT_W-1:0]  rank   [DEPTH];
  logic [DEPTH-1:0]         lo_sel;
  logic [DEPTH-1:0]         hi_sel;
  logic [DEPTH-1:0]         lo_sel_next;
  logic [DEPTH-1:0]         hi_sel_next;
  logic signed [DATA_W-1:0] diff;
  logic signed [DATA_W-1:0] lo_val;
  logic signed [DATA_W-1:0] hi_val;
  logic signed [DATA_W:0]   pair_sum;

  // The difference of two 16-bit values always fits in 17 bits.
  assign diff = {sample[SAMPLE_W-1], sample} - {offset[SAMPLE_W-1], offset};

  // Ring window; the zeros after reset take part in the first medians.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        window[i] <= '0;
      end
    end else if (ctl.wr_en) begin
      window[wr_pos] <= diff;
    end
  end

  // Rank of each entry in sorted order; equal values are ordered by slot,
  // so every rank occurs exactly once.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      rank[i] = '0;
      for (int j = 0; j < DEPTH; j++) begin
        if (j != i) begin
          if ((window[j] < window[i]) || ((window[j] == window[i]) && (j < i))) begin
            rank[i] = rank[i] + CNT_W'(1);
          end
        end
      end
      lo_sel_next[i] = (rank[i] == CNT_W'(MID_LO));
      hi_sel_next[i] = (rank[i] == CNT_W'(MID_HI));
    end
  end

  // Rank stage: hold a copy of the window with its two middle-rank flags.
  always_ff @(posedge clk) begin
    if (ctl.rank_en) begin
      for (int i = 0; i < DEPTH; i++) begin
        snap[i] <= window[i];
      end
      lo_sel <= lo_sel_next;
      hi_sel <= hi_sel_next;
    end
  end

  // Pick the two middle values; for an odd depth they are the same entry.
  always_comb begin
    lo_val = '0;
    hi_val = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (lo_sel[i]) begin
        lo_val = lo_val | snap[i];
      end
      if (hi_sel[i]) begin
        hi_val = hi_val | snap[i];
      end
    end
  end

  // Floor of the mean: an arithmetic shift of the 18-bit sum.
  assign pair_sum = {lo_val[DATA_W-1], lo_val} + {hi_val[DATA_W-1], hi_val};
  assign median   = pair_sum[DATA_W:1];

endmodule

`default_nettype wire

FILE: hdl/tamf_merge.sv
// Output stage that merges the three lane medians into one registered beat.
`default_nettype none

module tamf_merge (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   in_valid,
  output logic                                  in_ready,
  input  wire signed [tamf_pkg::DATA_W-1:0]     median_x,
  input  wire signed [tamf_pkg::DATA_W-1:0]     median_y,
  input  wire signed [tamf_pkg::DATA_W-1:0]     median_z,
  output logic                                  m_axis_tvalid,
  input  wire                                   m_axis_tready,
  // Fields from bit 0: median_x, median_y, median_z, zero padding.
  output logic [tamf_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);
  import tamf_pkg::*;

  // The register takes a new beat when empty or when its beat leaves.
  assign in_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_ready) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      m_axis_tdata <= {{OUT_PAD_W{1'b0}}, median_z, median_y, median_x};
    end
  end

endmodule

`default_nettype wire

FILE: hdl/three_axis_median_filter.sv
// A result beat follows its accepted sample beat through the window write,
// the rank register and the output register; one beat per cycle while
// m_axis_tready allows, as these steps run overlapped.
// Reset clears the offsets, the three windows to zero, the write pointer
// and all stage valid bits; no clearing pass is needed.
`default_nettype none

module three_axis_median_filter #(
  parameter int WINDOW_DEPTH = 5
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 cfg_we,
  input  wire  [tamf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [tamf_pkg::SAMPLE_W-1:0]       cfg_data,
  input  wire                                 s_axis_tvalid,
  output logic                                s_axis_tready,
  // Fields from bit 0: sample_x, sample_y, sample_z.
  input  wire  [tamf_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  wire                                 m_axis_tready,
  // Fields from bit 0: median_x, median_y, median_z, zero padding.
  output logic [tamf_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
  import tamf_pkg::*;

  localparam int PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

  logic signed [SAMPLE_W-1:0] offset_x;
  logic signed [SAMPLE_W-1:0] offset_y;
  logic signed [SAMPLE_W-1:0] offset_z;
  logic [PTR_W-1:0]           wr_ptr;
  logic [PTR_W-1:0]           wr_ptr_next;
  logic                       valid_w;
  logic                       valid_r;
  logic                       ready_r;
  logic                       ready_o;
  logic                       accept;
  tamf_lane_ctl_t             lane_ctl;
  logic signed [DATA_W-1:0]   median_x;
  logic signed [DATA_W-1:0]   median_y;
  logic signed [DATA_W-1:0]   median_z;

  // Offset registers; writes to unused indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x <= '0;
      offset_y <= '0;
      offset_z <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OFFSET_X: offset_x <= cfg_data;
        REG_OFFSET_Y: offset_y <= cfg_data;
        REG_OFFSET_Z: offset_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // Each stage moves on when the next one is empty or moving on too.
  assign ready_r       = !valid_r || ready_o;
  assign s_axis_tready = !valid_w || ready_r;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Lane controls in declaration order: window write, then rank capture.
  assign lane_ctl = {accept, valid_w && ready_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_w <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        valid_w <= s_axis_tvalid;
      end
      if (ready_r) begin
        valid_r <= valid_w;
      end
    end
  end

  // Shared write pointer, wrapping at the window depth.
  assign wr_ptr_next = (wr_ptr == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
    end else if (accept) begin
      wr_ptr <= wr_ptr_next;
    end
  end

  // One lane per axis.
  tamf_lane #(.DEPTH(WINDOW_DEPTH)) u_lane_x (
    .clk    (clk),
    .rst    (rst),
    .ctl    (lane_ctl),
    .wr_pos (wr_ptr),
    .sample (s_axis_tdata[SAMPLE_W-1:0]),
    .offset (offset_x),
    .median (median_x)
  );

  tamf_lane #(.DEPTH(WINDOW_DEPTH)) u_lane_y (
    .clk    (clk),
    .rst    (rst),
    .ctl    (lane_ctl),
    .wr_pos (wr_ptr),
    .sample (s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W]),
    .offset (offset_y),
    .median (median_y)
  );

  tamf_lane #(.DEPTH(WINDOW_DEPTH)) u_lane_z (
    .clk    (clk),
    .rst    (rst),
    .ctl    (lane_ctl),
    .wr_pos (wr_ptr),
    .sample (s_axis_tdata[3*SAMPLE_W-1:2*SAMPLE_W]),
    .offset (offset_z),
    .median (median_z)
  );

  // Merge the three medians into the output register.
  tamf_merge u_merge (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (valid_r),
    .in_ready      (ready_o),
    .median_x      (median_x),
    .median_y      (median_y),
    .median_z      (median_z),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

`ifndef NO_ASSERTIONS
  // The pointer never leaves the window.
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    wr_ptr <= PTR_W'(WINDOW_DEPTH - 1))
    else $error("write pointer beyond window depth");

  // An empty window stage never holds off the input.
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !valid_w |-> s_axis_tready)
    else $error("input stalled with empty window stage");

  // A ranked item blocked by the output register is kept.
  a_rank_hold: assert property (@(posedge clk) disable iff (rst)
    (valid_r && !ready_o) |=> valid_r)
    else $error("ranked item dropped while output stalled");
`endif

endmodule

`default_nettype wire
